@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define URF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is high.
`define URF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds through reset.
`define URF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/urf_pkg.sv @@
// Shared types and codes for the unwind record filter.
// No dependencies; every design and checker module imports this package.
package urf_pkg;

   // input opcodes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_DATA  = 2'd2;
   localparam logic [1:0] OP_END   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_RELOC = 2'd1;
   localparam logic [1:0] KIND_SIZE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TRUNC     = 2'd1;
   localparam logic [1:0] ERR_LEN64     = 2'd2;
   localparam logic [1:0] ERR_UNMATCHED = 2'd3;

   // front phase codes
   localparam logic [1:0] PH_LOADING   = 2'd0;
   localparam logic [1:0] PH_STREAMING = 2'd1;
   localparam logic [1:0] PH_DRAINED   = 2'd2;
   localparam logic [1:0] PH_CLOSED    = 2'd3;

   localparam logic [3:0]  LEN_BYTES  = 4'd4;
   localparam logic [3:0]  HDR_BYTES  = 4'd8;
   localparam logic [31:0] LEN_64BIT  = 32'hffff_ffff;
   localparam logic [31:0] ID_OFFSET  = 32'd4;
   localparam logic [31:0] PC_OFFSET  = 32'd8;

   localparam int MAX_RELOCS_DEFAULT = 256;
   localparam int QUEUE_DEPTH        = 4;

   // sub-step of the final result of a header command
   localparam logic [3:0] SUB_LAST_BYTE  = 4'd7;
   localparam logic [3:0] SUB_RELOC      = 4'd8;

   // one command from front to back: a single result word, or a whole
   // record header (8 bytes, plus a relocation word when matched)
   typedef struct packed {
      logic        is_hdr;
      logic        matched;
      logic [1:0]  kind;
      logic [7:0]  byte_val;
      logic [31:0] offset;
      logic [1:0]  err;
      logic [63:0] hdr;
   } urf_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } urf_qstat_type;

endpackage

@@ src/urf_front.sv @@
// Front end: accepts items, tracks record framing and the relocation
// table, and issues at most one command per item. Depends on urf_pkg.
module urf_front #(
   parameter int MAX_RELOCS = urf_pkg::MAX_RELOCS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [1:0]          req_opcode,
   input  logic [31:0]         req_reloc_offset,
   input  logic [7:0]          req_data_byte,
   output logic                cmd_valid,
   output urf_pkg::urf_cmd_type cmd
);
   import urf_pkg::*;

   localparam int CNT_W = $clog2(MAX_RELOCS + 1);
   localparam int IDX_W = (MAX_RELOCS > 1) ? $clog2(MAX_RELOCS) : 1;

   logic [31:0]      reloc_mem [MAX_RELOCS];
   logic [31:0]      rd_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] next_ff, next_in;
   logic [31:0]      rstart_ff, rstart_in;
   logic [3:0]       nbytes_ff, nbytes_in;
   logic [31:0]      rlen_ff, rlen_in;
   logic [7:0]       hbuf_ff [8];
   logic [7:0]       hbuf_in [8];
   logic [31:0]      kept_ff, kept_in;
   logic             keep_ff, keep_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       err_ff, err_in;
   logic             load_we;

   logic [3:0]       nb1;
   logic [31:0]      len_word, id_word, id_out;
   logic             matched, keep_hdr;
   logic [31:0]      rlen_hdr, rlen_body;
   logic [CNT_W-1:0] next_hdr;

   assign nb1       = nbytes_ff + 4'd1;
   assign len_word  = {req_data_byte, hbuf_ff[2], hbuf_ff[1], hbuf_ff[0]};
   assign id_word   = {req_data_byte, hbuf_ff[6], hbuf_ff[5], hbuf_ff[4]};
   // prefetched entry for the pending relocation
   assign matched   = (rstart_ff + PC_OFFSET) == rd_ff;
   assign keep_hdr  = (id_word == 32'd0) || matched;
   assign id_out    = matched ? (kept_ff + ID_OFFSET) : id_word;
   assign rlen_hdr  = rlen_ff - ID_OFFSET;
   assign rlen_body = rlen_ff - 32'd1;
   assign next_hdr  = matched ? (next_ff + CNT_W'(1)) : next_ff;

   always_comb begin
      count_in  = count_ff;
      next_in   = next_ff;
      rstart_in = rstart_ff;
      nbytes_in = nbytes_ff;
      rlen_in   = rlen_ff;
      hbuf_in   = hbuf_ff;
      kept_in   = kept_ff;
      keep_in   = keep_ff;
      phase_in  = phase_ff;
      err_in    = err_ff;
      load_we   = 1'b0;
      cmd_valid = 1'b0;
      cmd       = '0;
      if (req_accept) begin
         unique case (req_opcode)
            OP_START: begin
               count_in  = '0;
               next_in   = '0;
               rstart_in = '0;
               nbytes_in = '0;
               rlen_in   = '0;
               for (int i = 0; i < 8; i++) hbuf_in[i] = 8'd0;
               kept_in   = '0;
               keep_in   = 1'b0;
               phase_in  = PH_LOADING;
               err_in    = ERR_NONE;
            end
            OP_LOAD: begin
               if (phase_ff == PH_LOADING && err_ff == ERR_NONE &&
                   count_ff < CNT_W'(MAX_RELOCS)) begin
                  load_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_DATA: begin
               if (err_ff == ERR_NONE &&
                   (phase_ff == PH_LOADING || phase_ff == PH_STREAMING)) begin
                  if (phase_ff == PH_LOADING && count_ff == '0) begin
                     phase_in = PH_DRAINED;
                  end else begin
                     phase_in = PH_STREAMING;
                     if (nbytes_ff < HDR_BYTES) begin
                        hbuf_in[nbytes_ff[2:0]] = req_data_byte;
                        nbytes_in = nb1;
                        if (nb1 == LEN_BYTES) begin
                           if (len_word == LEN_64BIT) begin
                              err_in    = ERR_LEN64;
                              cmd_valid = 1'b1;
                              cmd.kind  = KIND_ERROR;
                              cmd.err   = ERR_LEN64;
                           end else if (len_word == 32'd0) begin
                              // terminator while relocations still pending
                              err_in    = ERR_UNMATCHED;
                              cmd_valid = 1'b1;
                              cmd.kind  = KIND_ERROR;
                              cmd.err   = ERR_UNMATCHED;
                           end else begin
                              rlen_in = len_word;
                           end
                        end else if (nb1 == HDR_BYTES) begin
                           rstart_in = rstart_ff + ID_OFFSET + rlen_ff;
                           rlen_in   = rlen_hdr;
                           keep_in   = keep_hdr;
                           if (keep_hdr) begin
                              cmd_valid   = 1'b1;
                              cmd.is_hdr  = 1'b1;
                              cmd.matched = matched;
                              cmd.offset  = kept_ff + PC_OFFSET;
                              cmd.hdr     = {id_out, hbuf_ff[3], hbuf_ff[2],
                                             hbuf_ff[1], hbuf_ff[0]};
                              kept_in     = kept_ff + PC_OFFSET;
                              next_in     = next_hdr;
                           end
                           if (rlen_hdr == 32'd0) begin
                              nbytes_in = '0;
                              keep_in   = 1'b0;
                              if (next_hdr >= count_ff) phase_in = PH_DRAINED;
                           end
                        end
                     end else begin
                        if (keep_ff) begin
                           cmd_valid    = 1'b1;
                           cmd.kind     = KIND_BYTE;
                           cmd.byte_val = req_data_byte;
                           kept_in      = kept_ff + 32'd1;
                        end
                        rlen_in = rlen_body;
                        if (rlen_body == 32'd0) begin
                           nbytes_in = '0;
                           keep_in   = 1'b0;
                           if (next_ff >= count_ff) phase_in = PH_DRAINED;
                        end
                     end
                  end
               end
            end
            OP_END: begin
               cmd_valid = 1'b1;
               phase_in  = PH_CLOSED;
               if (err_ff != ERR_NONE) begin
                  cmd.kind = KIND_ERROR;
                  cmd.err  = err_ff;
               end else if (phase_ff == PH_STREAMING && nbytes_ff != 4'd0) begin
                  err_in   = ERR_TRUNC;
                  cmd.kind = KIND_ERROR;
                  cmd.err  = ERR_TRUNC;
               end else if (next_ff < count_ff) begin
                  err_in   = ERR_UNMATCHED;
                  cmd.kind = KIND_ERROR;
                  cmd.err  = ERR_UNMATCHED;
               end else begin
                  cmd.kind   = KIND_SIZE;
                  cmd.offset = kept_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // relocation table: one write port, one registered read
   always_ff @(posedge clock) begin
      if (load_we) reloc_mem[count_ff[IDX_W-1:0]] <= req_reloc_offset;
      rd_ff <= reloc_mem[next_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         next_ff   <= '0;
         rstart_ff <= '0;
         nbytes_ff <= '0;
         rlen_ff   <= '0;
         for (int i = 0; i < 8; i++) hbuf_ff[i] <= 8'd0;
         kept_ff   <= '0;
         keep_ff   <= 1'b0;
         phase_ff  <= PH_LOADING;
         err_ff    <= ERR_NONE;
      end else begin
         count_ff  <= count_in;
         next_ff   <= next_in;
         rstart_ff <= rstart_in;
         nbytes_ff <= nbytes_in;
         rlen_ff   <= rlen_in;
         hbuf_ff   <= hbuf_in;
         kept_ff   <= kept_in;
         keep_ff   <= keep_in;
         phase_ff  <= phase_in;
         err_ff    <= err_in;
      end
   end

endmodule

@@ src/urf_queue.sv @@
// Small command queue between front and back.
// Depends on urf_pkg for the command type and depth.
module urf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  urf_pkg::urf_cmd_type  push_cmd,
   input  logic                  pop,
   output urf_pkg::urf_cmd_type  head,
   output urf_pkg::urf_qstat_type stat
);
   import urf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   urf_cmd_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [PTR_W:0]    cnt_ff, cnt_in;

   assign head       = entry_ff[rd_ff];
   assign stat.full  = (cnt_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ src/urf_back.sv @@
// Back end: expands queued commands into result words and holds the
// current word in the output register. Depends on urf_pkg.
module urf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  urf_pkg::urf_cmd_type   head,
   input  urf_pkg::urf_qstat_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_byte_out,
   output logic [31:0]            rsp_offset_out,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last
);
   import urf_pkg::*;

   logic        valid_ff, valid_in;
   logic [3:0]  sub_ff, sub_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [31:0] off_ff, off_in;
   logic [1:0]  err_ff, err_in;
   logic        last_ff, last_in;
   logic        load, final_sub;

   assign final_sub = !head.is_hdr ||
                      (head.matched ? (sub_ff == SUB_RELOC) : (sub_ff == SUB_LAST_BYTE));
   assign load      = !q_stat.empty && (!valid_ff || rsp_pop);
   assign q_pop     = load && final_sub;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      off_in   = off_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = final_sub ? 4'd0 : sub_ff + 4'd1;
         last_in  = final_sub;
         if (!head.is_hdr) begin
            kind_in = head.kind;
            byte_in = head.byte_val;
            off_in  = head.offset;
            err_in  = head.err;
         end else if (sub_ff == SUB_RELOC) begin
            kind_in = KIND_RELOC;
            byte_in = 8'd0;
            off_in  = head.offset;
            err_in  = ERR_NONE;
         end else begin
            kind_in = KIND_BYTE;
            byte_in = head.hdr[{sub_ff[2:0], 3'b000} +: 8];
            off_in  = 32'd0;
            err_in  = ERR_NONE;
         end
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      off_ff  <= off_in;
      err_ff  <= err_in;
      last_ff <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_byte_out   = byte_ff;
   assign rsp_offset_out = off_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;

endmodule

@@ src/unwind_record_filter.sv @@
// Top level of the unwind record filter: front, command queue, back.
// Depends on urf_pkg, urf_front, urf_queue, urf_back.
//
//   channel   direction  handshake       payload
//   req       in         push / full     opcode, reloc_offset, data_byte
//   rsp       out        empty / pop     kind, byte_out, offset_out,
//                                        error_code, last
//
// One word enters per cycle while the command queue has room; each word
// is classified in the cycle it is taken and leaves at most one command.
// The back end sends one result word per cycle while rsp is popped:
// a kept header is 8 words, 9 with its relocation word, so a matched
// header briefly backs up the queue. The relocation table read is
// registered and prefetched. Reset is synchronous and empties the queue
// and output register; the table itself is not cleared. A stalled rsp
// side fills the queue, then raises full.
module unwind_record_filter #(
   parameter int MAX_RELOCS = urf_pkg::MAX_RELOCS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_reloc_offset,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_out,
   output logic [31:0] rsp_offset_out,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);
   import urf_pkg::*;

   logic          req_accept;
   logic          cmd_valid;
   urf_cmd_type   cmd;
   urf_cmd_type   head;
   urf_qstat_type q_stat;
   logic          q_pop;

   // full comes straight off the queue count, no path from rsp_pop
   assign req_full   = q_stat.full;
   assign req_accept = req_push && !q_stat.full;

   // framing, relocation matching and id rewrite
   urf_front #(
      .MAX_RELOCS(MAX_RELOCS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_opcode      (req_opcode),
      .req_reloc_offset(req_reloc_offset),
      .req_data_byte   (req_data_byte),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd)
   );

   // decouples byte intake from multi-word header output
   urf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_valid),
      .push_cmd(cmd),
      .pop     (q_pop),
      .head    (head),
      .stat    (q_stat)
   );

   // result expansion and output register
   urf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_stat        (q_stat),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_kind      (rsp_kind),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_offset_out(rsp_offset_out),
      .rsp_error_code(rsp_error_code),
      .rsp_last      (rsp_last)
   );

endmodule

@@ src/urf_checker.sv @@
// Port-level checks for unwind_record_filter, bound to the top level.
// Depends on urf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module urf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_byte_out,
   input logic [31:0] rsp_offset_out,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_last
);
   import urf_pkg::*;

   // reset drops the output register
   `URF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty)

   // a waiting word holds while not popped
   `URF_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_kind) && $stable(rsp_byte_out) && $stable(rsp_offset_out) && $stable(rsp_last))

   // error and size words are always the sole word of their item
   `URF_ASSERT_IMPL(a_single_last, clock, reset, !rsp_empty && (rsp_kind == KIND_ERROR || rsp_kind == KIND_SIZE), rsp_last)

   // error code is set exactly on error words
   `URF_ASSERT_IMPL(a_err_code, clock, reset, !rsp_empty, (rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE))

endmodule

bind unwind_record_filter urf_checker u_urf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_kind      (rsp_kind),
   .rsp_byte_out  (rsp_byte_out),
   .rsp_offset_out(rsp_offset_out),
   .rsp_error_code(rsp_error_code),
   .rsp_last      (rsp_last)
);
